### rtl/http_byte_range_parser_core_macros.svh
// Assertion macros shared by the byte-range parser RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef HTTP_BYTE_RANGE_PARSER_CORE_MACROS_SVH
`define HTTP_BYTE_RANGE_PARSER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define HBRP_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define HBRP_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/hbrp_pkg.sv
// Shared types, constants and helpers for the HTTP byte-range parser.
// No dependencies; imported by every module of the block.
package hbrp_pkg;

  // Offset width and field widths
  localparam int OFFSET_BITS = 63;
  localparam int LEN_BITS    = 63;
  localparam int MIN_LEN     = 7;
  localparam int PREFIX_LEN  = 6;

  typedef logic [OFFSET_BITS-1:0] offset_t;
  typedef logic [LEN_BITS-1:0]    len_t;

  localparam offset_t      OFF_MAX    = '1;
  localparam offset_t      DIG_CUTOFF = OFF_MAX / 10;
  localparam logic [3:0]   DIG_CUTLIM = 4'(OFF_MAX % 10);
  localparam logic [2:0]   CNT_MIN    = 3'(MIN_LEN);
  localparam logic [2:0]   PFX_DONE   = 3'(PREFIX_LEN);

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_CASE  = 8'h20;

  // Parse phases
  typedef enum logic [2:0] {
    PH_PREFIX,
    PH_LEAD_SP,
    PH_START_DIG,
    PH_SP_BEFORE_DASH,
    PH_AFTER_DASH,
    PH_SUFFIX_FIRST,
    PH_END_DIG,
    PH_TRAIL_SP
  } phase_t;

  // Parse outcome handed from the parser to the resolver
  typedef struct packed {
    logic    ok;        // syntax good, long enough, complete range form
    logic    open_end;  // "start-" with no end number
    logic    suffix;    // "-length" form
    offset_t first;
    offset_t second;
    offset_t len;       // content length, saturated to the offset maximum
  } fin_t;

  // Lower-case "bytes=" by position
  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h62;
      3'd1:    ch = 8'h79;
      3'd2:    ch = 8'h74;
      3'd3:    ch = 8'h65;
      3'd4:    ch = 8'h73;
      3'd5:    ch = 8'h3D;
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

endpackage

### rtl/hbrp_parser.sv
// Per-byte parse state machine with decimal accumulators and the outcome register.
// Depends on hbrp_pkg and http_byte_range_parser_core_macros.svh.
`include "http_byte_range_parser_core_macros.svh"

module hbrp_parser (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  input  logic [7:0]     item_char,
  input  logic           item_last,
  input  hbrp_pkg::len_t item_len,
  output logic           item_take,
  output logic           fin_valid,
  output hbrp_pkg::fin_t fin,
  input  logic           fin_take
);
  import hbrp_pkg::*;

  phase_t     phase, phase_next;
  logic [2:0] prefix_matched, prefix_matched_next;
  logic [2:0] chars_seen, chars_seen_next;
  offset_t    first_number, first_number_next;
  offset_t    second_number, second_number_next;
  logic       suffix_form, suffix_form_next;
  logic       malformed, malformed_next;
  logic       terminated, terminated_next;

  logic [7:0] lc;
  logic       is_dig;
  logic [3:0] dval;
  offset_t    acc, acc_new;
  logic       acc_ovf;
  logic       err;
  offset_t    len_sat;
  fin_t       fin_next;

  // Bytes are taken only when the outcome register is empty or draining
  assign item_take = item_valid && (!fin_valid || fin_take);

  // Byte classification and the shared multiply-by-ten accumulate
  always_comb begin
    lc      = ((item_char >= CH_UP_A) && (item_char <= CH_UP_Z)) ? (item_char | CH_CASE)
                                                                 : item_char;
    is_dig  = (item_char >= CH_ZERO) && (item_char <= CH_NINE);
    dval    = item_char[3:0];
    acc     = ((phase == PH_LEAD_SP) || (phase == PH_START_DIG)) ? first_number
                                                                 : second_number;
    acc_ovf = (acc > DIG_CUTOFF) || ((acc == DIG_CUTOFF) && (dval > DIG_CUTLIM));
    acc_new = (acc << 3) + (acc << 1) + OFFSET_BITS'(dval);
  end

  // Next parse state for one byte
  always_comb begin
    phase_next          = phase;
    prefix_matched_next = prefix_matched;
    chars_seen_next     = (chars_seen != CNT_MIN) ? chars_seen + 3'd1 : chars_seen;
    first_number_next   = first_number;
    second_number_next  = second_number;
    suffix_form_next    = suffix_form;
    terminated_next     = terminated;
    err                 = 1'b0;

    if (!malformed && !terminated) begin
      if (item_char == CH_NUL) begin
        terminated_next = 1'b1;
      end else begin
        unique case (phase)
          PH_PREFIX: begin
            if ((prefix_matched < PFX_DONE) && (lc == prefix_char(prefix_matched))) begin
              prefix_matched_next = prefix_matched + 3'd1;
              if (prefix_matched_next == PFX_DONE) phase_next = PH_LEAD_SP;
            end else begin
              err = 1'b1;
            end
          end
          PH_LEAD_SP: begin
            if (item_char == CH_SPACE) begin
              phase_next = PH_LEAD_SP;
            end else if (item_char == CH_DASH) begin
              suffix_form_next = 1'b1;
              phase_next       = PH_SUFFIX_FIRST;
            end else if (is_dig) begin
              if (acc_ovf) err = 1'b1;
              else first_number_next = acc_new;
              phase_next = PH_START_DIG;
            end else begin
              err = 1'b1;
            end
          end
          PH_START_DIG: begin
            if (is_dig) begin
              if (acc_ovf) err = 1'b1;
              else first_number_next = acc_new;
            end else if (item_char == CH_SPACE) begin
              phase_next = PH_SP_BEFORE_DASH;
            end else if (item_char == CH_DASH) begin
              phase_next = PH_AFTER_DASH;
            end else begin
              err = 1'b1;
            end
          end
          PH_SP_BEFORE_DASH: begin
            if (item_char == CH_DASH) phase_next = PH_AFTER_DASH;
            else if (item_char != CH_SPACE) err = 1'b1;
          end
          PH_AFTER_DASH: begin
            if (is_dig) begin
              if (acc_ovf) err = 1'b1;
              else second_number_next = acc_new;
              phase_next = PH_END_DIG;
            end else if (item_char != CH_SPACE) begin
              err = 1'b1;
            end
          end
          PH_SUFFIX_FIRST: begin
            if (is_dig) begin
              if (acc_ovf) err = 1'b1;
              else second_number_next = acc_new;
              phase_next = PH_END_DIG;
            end else begin
              err = 1'b1;
            end
          end
          PH_END_DIG: begin
            if (is_dig) begin
              if (acc_ovf) err = 1'b1;
              else second_number_next = acc_new;
            end else if (item_char == CH_SPACE) begin
              phase_next = PH_TRAIL_SP;
            end else begin
              err = 1'b1;
            end
          end
          PH_TRAIL_SP: begin
            if (item_char != CH_SPACE) err = 1'b1;
          end
          default: err = 1'b1;
        endcase
      end
    end

    malformed_next = malformed || err;
  end

  // Outcome of the value, taken when its last byte goes through
  always_comb begin
    len_sat           = (item_len > LEN_BITS'(OFF_MAX)) ? OFF_MAX : OFFSET_BITS'(item_len);
    fin_next.ok       = !malformed_next && (chars_seen_next == CNT_MIN) &&
                        ((phase_next == PH_AFTER_DASH) || (phase_next == PH_END_DIG) ||
                         (phase_next == PH_TRAIL_SP));
    fin_next.open_end = (phase_next == PH_AFTER_DASH);
    fin_next.suffix   = suffix_form_next;
    fin_next.first    = first_number_next;
    fin_next.second   = second_number_next;
    fin_next.len      = len_sat;
  end

  // Parse state; cleared after each value's last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_PREFIX;
      prefix_matched <= '0;
      chars_seen     <= '0;
      first_number   <= '0;
      second_number  <= '0;
      suffix_form    <= 1'b0;
      malformed      <= 1'b0;
      terminated     <= 1'b0;
      fin_valid      <= 1'b0;
    end else begin
      if (item_take && item_last) fin_valid <= 1'b1;
      else if (fin_take) fin_valid <= 1'b0;
      if (item_take) begin
        if (item_last) begin
          phase          <= PH_PREFIX;
          prefix_matched <= '0;
          chars_seen     <= '0;
          first_number   <= '0;
          second_number  <= '0;
          suffix_form    <= 1'b0;
          malformed      <= 1'b0;
          terminated     <= 1'b0;
        end else begin
          phase          <= phase_next;
          prefix_matched <= prefix_matched_next;
          chars_seen     <= chars_seen_next;
          first_number   <= first_number_next;
          second_number  <= second_number_next;
          suffix_form    <= suffix_form_next;
          malformed      <= malformed_next;
          terminated     <= terminated_next;
        end
      end
    end
  end

  // Outcome payload
  always_ff @(posedge clk) begin
    if (item_take && item_last) fin <= fin_next;
  end

  // Checks
  `HBRP_ASSERT_NXT(a_fin_hold, clk, rst, fin_valid && !fin_take, fin_valid && $stable(fin), "outcome changed while waiting")
  `HBRP_ASSERT_NXT(a_clear_after_last, clk, rst, item_take && item_last, (phase == PH_PREFIX) && (chars_seen == 3'd0) && !malformed && !terminated, "parse state not cleared after last byte")
  `HBRP_ASSERT_NXT(a_malformed_sticky, clk, rst, malformed && !(item_take && item_last), malformed, "error flag dropped within a value")

endmodule

### rtl/hbrp_resolve.sv
// Range resolution against the content length, and the result register.
// Depends on hbrp_pkg.
module hbrp_resolve (
  input  logic           clk,
  input  logic           rst,
  input  logic           fin_valid,
  input  hbrp_pkg::fin_t fin,
  output logic           fin_take,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           status,
  output hbrp_pkg::len_t range_start,
  output hbrp_pkg::len_t range_end
);
  import hbrp_pkg::*;

  offset_t start_val, end_val;
  logic    nonempty, good;

  // Result register is free when empty or being taken
  assign fin_take = fin_valid && (!out_valid || out_ready);

  // Offsets per form; emptiness tested on the operands in parallel
  always_comb begin
    if (fin.open_end) begin
      start_val = fin.first;
      end_val   = fin.len;
      nonempty  = fin.first < fin.len;
    end else if (fin.suffix) begin
      start_val = (fin.second > fin.len) ? '0 : fin.len - fin.second;
      end_val   = fin.len;
      nonempty  = (fin.len != '0) && (fin.second != '0);
    end else begin
      start_val = fin.first;
      end_val   = (fin.second >= fin.len) ? fin.len : fin.second + OFFSET_BITS'(1);
      nonempty  = (fin.first < fin.len) && (fin.first <= fin.second);
    end
    good = fin.ok && nonempty;
  end

  // Result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload; rejected ranges give zero offsets
  always_ff @(posedge clk) begin
    if (fin_take) begin
      status      <= !good;
      range_start <= good ? LEN_BITS'(start_val) : '0;
      range_end   <= good ? LEN_BITS'(end_val) : '0;
    end
  end

endmodule

### rtl/http_byte_range_parser_core.sv
// HTTP single byte-range parser: takes a Range header value one byte per transfer
// (is_last on the final byte) and gives one transfer per value holding status,
// start offset and exclusive end offset clipped to total_length. A new byte is
// accepted every cycle unless output back-pressure stalls the input; the
// multiply-by-ten accumulate in the parser is combinational. After a value's last
// byte is accepted into the input register, its result passes through the parse
// outcome register and then the result register.
// Output back-pressure stalls the input only once all three registers are full.
// Depends on hbrp_pkg, hbrp_parser and hbrp_resolve.
module http_byte_range_parser_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     char_in,
  input  logic           is_last,
  input  hbrp_pkg::len_t total_length,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           status,
  output hbrp_pkg::len_t range_start,
  output hbrp_pkg::len_t range_end
);
  import hbrp_pkg::*;

  logic       in_q_valid;
  logic [7:0] in_q_char;
  logic       in_q_last;
  len_t       in_q_len;
  logic       item_take;
  logic       fin_valid;
  logic       fin_take;
  fin_t       fin;

  assign in_ready = !in_q_valid || item_take;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q_char <= char_in;
      in_q_last <= is_last;
      in_q_len  <= total_length;
    end
  end

  hbrp_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .item_valid (in_q_valid),
    .item_char  (in_q_char),
    .item_last  (in_q_last),
    .item_len   (in_q_len),
    .item_take  (item_take),
    .fin_valid  (fin_valid),
    .fin        (fin),
    .fin_take   (fin_take)
  );

  hbrp_resolve u_resolve (
    .clk         (clk),
    .rst         (rst),
    .fin_valid   (fin_valid),
    .fin         (fin),
    .fin_take    (fin_take),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .range_start (range_start),
    .range_end   (range_end)
  );

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for http_byte_range_parser_core: byte-stream driver, result monitor,
// and an in-bench parser that predicts status and offsets per header value.
// Depends on hbrp_pkg and the parser RTL only.
module testbench;
  import hbrp_pkg::*;

  // One byte transfer on the input channel
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    len_t       total;
  } hdr_byte_t;

  // One result transfer
  typedef struct packed {
    logic    refused;
    offset_t first_off;
    offset_t end_off;
  } byte_range_t;

  localparam logic [47:0] BYTES_PREFIX = "bytes=";
  localparam int          STALL_LIMIT  = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic       in_valid     = 1'b0;
  logic       in_ready;
  logic [7:0] char_in      = '0;
  logic       is_last      = 1'b0;
  len_t       total_length = '0;
  logic       out_valid;
  logic       out_ready    = 1'b0;
  logic       status;
  len_t       range_start;
  len_t       range_end;

  // Pending bytes, expected ranges, scratch for building one header value
  hdr_byte_t   byte_q[$];
  byte_range_t range_q[$];
  logic [7:0]  draft[$];

  // Parser state of the predictor
  phase_t      parse_ph    = PH_PREFIX;
  logic [2:0]  pfx_hits    = '0;
  logic [2:0]  seen_cnt    = '0;
  offset_t     start_num   = '0;
  offset_t     second_num  = '0;
  bit          suffix_seen = 1'b0;
  bit          bad_syntax  = 1'b0;
  bit          hit_nul     = 1'b0;

  bit in_taken     = 1'b0;
  bit out_taken    = 1'b0;
  int send_wait    = 0;
  int recv_wait    = 0;
  int send_gap_max = 0;
  int recv_gap_max = 0;
  int idle_cycles  = 0;
  int err_count    = 0;
  int items_queued = 0;
  int bytes_taken  = 0;
  int ranges_seen  = 0;
  int ranges_good  = 0;

  http_byte_range_parser_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .char_in      (char_in),
    .is_last      (is_last),
    .total_length (total_length),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .range_start  (range_start),
    .range_end    (range_end)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    err_count++;
  endtask

  // ---------------------------------------------------------------- predictor

  task automatic clear_parse_state();
    parse_ph    = PH_PREFIX;
    pfx_hits    = '0;
    seen_cnt    = '0;
    start_num   = '0;
    second_num  = '0;
    suffix_seen = 1'b0;
    bad_syntax  = 1'b0;
    hit_nul     = 1'b0;
  endtask

  // Decimal accumulate; anything past the 63-bit offset range is an overflow
  task automatic accumulate(inout offset_t num, input logic [7:0] ch, inout bit fail);
    logic [67:0] wide;
    wide = {5'd0, num} * 68'd10 + 68'(ch - CH_ZERO);
    if (|wide[67:63]) fail = 1'b1;
    else num = wide[62:0];
  endtask

  task automatic advance_phase(input logic [7:0] ch);
    logic [7:0] folded;
    bit         digit;
    bit         fail;
    folded = (ch >= CH_UP_A && ch <= CH_UP_Z) ? ch + CH_CASE : ch;
    digit  = (ch >= CH_ZERO && ch <= CH_NINE);
    fail   = 1'b0;
    case (parse_ph)
      PH_PREFIX: begin
        if (pfx_hits < PREFIX_LEN && folded == BYTES_PREFIX[47 - 8*pfx_hits -: 8]) begin
          pfx_hits++;
          if (pfx_hits == PREFIX_LEN) parse_ph = PH_LEAD_SP;
        end else fail = 1'b1;
      end
      PH_LEAD_SP: begin
        if (ch == CH_SPACE) ;
        else if (ch == CH_DASH) begin
          suffix_seen = 1'b1;
          parse_ph    = PH_SUFFIX_FIRST;
        end else if (digit) begin
          accumulate(start_num, ch, fail);
          parse_ph = PH_START_DIG;
        end else fail = 1'b1;
      end
      PH_START_DIG: begin
        if (digit) accumulate(start_num, ch, fail);
        else if (ch == CH_SPACE) parse_ph = PH_SP_BEFORE_DASH;
        else if (ch == CH_DASH) parse_ph = PH_AFTER_DASH;
        else fail = 1'b1;
      end
      PH_SP_BEFORE_DASH: begin
        if (ch == CH_DASH) parse_ph = PH_AFTER_DASH;
        else if (ch != CH_SPACE) fail = 1'b1;
      end
      PH_AFTER_DASH: begin
        if (digit) begin
          accumulate(second_num, ch, fail);
          parse_ph = PH_END_DIG;
        end else if (ch != CH_SPACE) fail = 1'b1;
      end
      PH_SUFFIX_FIRST: begin
        if (digit) begin
          accumulate(second_num, ch, fail);
          parse_ph = PH_END_DIG;
        end else fail = 1'b1;
      end
      PH_END_DIG: begin
        if (digit) accumulate(second_num, ch, fail);
        else if (ch == CH_SPACE) parse_ph = PH_TRAIL_SP;
        else fail = 1'b1;
      end
      PH_TRAIL_SP: begin
        if (ch != CH_SPACE) fail = 1'b1;
      end
      default: fail = 1'b1;
    endcase
    if (fail) bad_syntax = 1'b1;
  endtask

  // Feeds one accepted byte; on the last byte hands back the range it resolves to
  task automatic parse_range_byte(input logic [7:0] ch, input logic last, input len_t total,
                                  output bit emit, output byte_range_t res);
    bit      good;
    offset_t lo;
    offset_t hi;
    emit = 1'b0;
    res  = '{refused: 1'b1, first_off: '0, end_off: '0};
    lo   = '0;
    hi   = '0;
    if (seen_cnt < MIN_LEN) seen_cnt++;
    if (!bad_syntax && !hit_nul) begin
      if (ch == CH_NUL) hit_nul = 1'b1;
      else advance_phase(ch);
    end
    if (last) begin
      emit = 1'b1;
      good = !bad_syntax && seen_cnt >= MIN_LEN;
      if (good) begin
        case (parse_ph)
          PH_AFTER_DASH: begin
            lo = start_num;
            hi = total;
          end
          PH_END_DIG, PH_TRAIL_SP: begin
            if (suffix_seen) begin
              lo = (second_num > total) ? '0 : total - second_num;
              hi = total;
            end else begin
              lo = start_num;
              hi = (second_num >= total) ? total : second_num + 1'b1;
            end
          end
          default: good = 1'b0;
        endcase
      end
      if (good && lo >= hi) good = 1'b0;
      if (good) res = '{refused: 1'b0, first_off: lo, end_off: hi};
      clear_parse_state();
    end
  endtask

  // ---------------------------------------------------------------- stimulus

  task automatic push_char(input logic [7:0] ch, input logic last, input len_t total);
    byte_q.push_back('{ch: ch, last: last, total: total});
    items_queued++;
  endtask

  task automatic push_text(input string s, input len_t total, input bit ends);
    for (int i = 0; i < s.len(); i++) push_char(s[i], ends && i == s.len() - 1, total);
  endtask

  task automatic draft_spaces();
    int n;
    n = $urandom_range(0, 5);
    if (n > 2) n = 0;
    repeat (n) draft.push_back(CH_SPACE);
  endtask

  // Mostly short numbers; some long, some right at the overflow boundary
  task automatic draft_number();
    int    kind;
    int    count;
    string limit_txt;
    kind = $urandom_range(0, 9);
    if (kind == 9) begin
      if ($urandom_range(0, 1)) limit_txt = "9223372036854775807";
      else limit_txt = "9223372036854775808";
      for (int i = 0; i < limit_txt.len(); i++) draft.push_back(limit_txt[i]);
    end else begin
      count = (kind < 7) ? $urandom_range(1, 4) :
              (kind == 7) ? $urandom_range(5, 17) : $urandom_range(18, 20);
      repeat (count) draft.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    end
  endtask

  task automatic queue_random_value();
    int          pick;
    int          form;
    int          pos;
    int          i;
    logic [7:0]  ch;
    logic [63:0] wide;
    len_t        total;
    draft.delete();
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      // pure noise
      repeat ($urandom_range(1, 12)) draft.push_back(8'($urandom_range(0, 255)));
    end else begin
      for (i = 0; i < PREFIX_LEN; i++) begin
        ch = BYTES_PREFIX[47 - 8*i -: 8];
        if (ch != "=" && $urandom_range(0, 1)) ch = ch - CH_CASE;
        draft.push_back(ch);
      end
      draft_spaces();
      form = $urandom_range(0, 2);
      if (form == 2) begin
        draft.push_back(CH_DASH);
        draft_number();
      end else begin
        draft_number();
        draft_spaces();
        draft.push_back(CH_DASH);
        draft_spaces();
        if (form == 0) draft_number();
      end
      draft_spaces();
      // occasional damage: a stray byte, a cut, or an embedded zero
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        draft[$urandom_range(0, draft.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (pick == 1) begin
        pos = $urandom_range(1, draft.size());
        while (draft.size() > pos) void'(draft.pop_back());
      end else if (pick == 2) begin
        draft.insert($urandom_range(0, draft.size() - 1), CH_NUL);
      end
    end
    pick = $urandom_range(0, 9);
    wide = {$urandom(), $urandom()};
    if (pick < 6) total = len_t'($urandom_range(0, 6000));
    else if (pick == 6) total = '0;
    else if (pick == 7) total = OFF_MAX;
    else if (pick == 8) total = wide[62:0];
    else total = len_t'($urandom_range(1, 20));
    for (i = 0; i < draft.size(); i++) begin
      wide = {$urandom(), $urandom()};
      if (i == draft.size() - 1) push_char(draft[i], 1'b1, total);
      else push_char(draft[i], 1'b0, wide[62:0]);
    end
  endtask

  // Sender holds off until all queued bytes went in and every range came back
  task automatic wait_results_drained();
    while (byte_q.size() != 0 || in_valid || range_q.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- drivers

  always @(negedge clk) begin : drive_bytes
    bit        took;
    hdr_byte_t nxt;
    took = in_taken;
    if (in_taken) begin
      in_taken  = 1'b0;
      send_wait = $urandom_range(0, send_gap_max);
    end
    if (!in_valid || took) begin
      if (send_wait > 0) begin
        send_wait--;
        in_valid <= 1'b0;
      end else if (byte_q.size() != 0) begin
        nxt = byte_q.pop_front();
        char_in      <= nxt.ch;
        is_last      <= nxt.last;
        total_length <= nxt.total;
        in_valid     <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : drive_ready
    if (out_taken) begin
      out_taken = 1'b0;
      recv_wait = $urandom_range(0, recv_gap_max);
    end
    if (recv_wait > 0) begin
      recv_wait--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin : watch_ports
    byte_range_t want;
    byte_range_t fresh;
    bit          emit;
    if (!rst) begin
      // check the result before predicting this cycle's byte
      if (out_valid && out_ready) begin
        out_taken = 1'b1;
        if (range_q.size() == 0) begin
          report_mismatch("unexpected result transfer, status", status, 0);
        end else begin
          want = range_q.pop_front();
          if (status !== want.refused) report_mismatch("status", status, want.refused);
          if (range_start !== want.first_off)
            report_mismatch("range_start", range_start, want.first_off);
          if (range_end !== want.end_off)
            report_mismatch("range_end", range_end, want.end_off);
          ranges_seen++;
          if (!want.refused) ranges_good++;
        end
      end
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        bytes_taken++;
        parse_range_byte(char_in, is_last, total_length, emit, fresh);
        if (emit) range_q.push_back(fresh);
      end
    end
  end

  // Watchdog: no transfer on either side for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("[%0t] no transfer for %0d cycles", $realtime, STALL_LIMIT);
      $display("testbench: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin : run_sequence
    int goal;
    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // directed values
    send_gap_max = 2;
    recv_gap_max = 2;
    push_text("bytes=0-499", 63'd1000, 1'b1);
    push_text("BYTES=500-", 63'd1000, 1'b1);
    push_text("Bytes=-200", 63'd1000, 1'b1);
    push_text("bytes=-5000", 63'd1000, 1'b1);
    push_text("bytes=0-99999", 63'd100, 1'b1);
    push_text("bytes=5-3", 63'd1000, 1'b1);
    push_text("bytes=0-", 63'd0, 1'b1);
    push_text("bytes=9223372036854775807-", OFF_MAX, 1'b1);
    push_text("bytes=9223372036854775808-", OFF_MAX, 1'b1);
    push_text("bytes=-1", OFF_MAX, 1'b1);
    push_text("byte", 63'd10, 1'b1);
    push_text("bytes=1", 63'd10, 1'b1);
    push_text("bytes=  7 -  9  ", 63'd50, 1'b1);
    push_text(" bytes=1-2", 63'd50, 1'b1);
    push_text("bytes=- 5", 63'd50, 1'b1);
    push_text("bytes=-", 63'd50, 1'b1);
    push_text("bytes=10-20 5", 63'd50, 1'b1);
    push_text("bytes=1-2x3", 63'd50, 1'b1);
    // zero byte ends the string; trailing bytes only count toward length
    push_text("bytes=1-5", 63'd40, 1'b0);
    push_char(CH_NUL, 1'b0, 63'd40);
    push_char("x", 1'b1, 63'd40);
    push_text("bytes=0-9", 63'd40, 1'b0);
    push_char(CH_NUL, 1'b1, 63'd40);
    push_char(CH_NUL, 1'b0, 63'd40);
    push_text("bytes=", 63'd40, 1'b1);
    push_text("bytes=1-2", 63'd40, 1'b0);
    push_char(8'hFF, 1'b1, 63'd40);
    wait_results_drained();

    // random values in batches with different idling; drained in between
    for (int batch = 0; batch < 4; batch++) begin
      case (batch)
        0: begin send_gap_max = 0;  recv_gap_max = 0;  end
        1: begin send_gap_max = 14; recv_gap_max = 14; end
        2: begin send_gap_max = 3;  recv_gap_max = 14; end
        default: begin send_gap_max = 14; recv_gap_max = 0; end
      endcase
      goal = items_queued + 150;
      while (items_queued < goal) queue_random_value();
      wait_results_drained();
    end

    repeat (8) @(posedge clk);
    $display("Parsed %0d header bytes into %0d results: %0d ranges satisfied, %0d refused.",
             bytes_taken, ranges_seen, ranges_good, ranges_seen - ranges_good);
    if (err_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("%0d mismatches", err_count);
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
